// ===== design/lptg_pkg.sv =====
// Package for the LED pulse train generator.
// Holds the time width, the reset constants, the LED mode codes and the beat structs.
// Stands alone; every other design file imports it.
package lptg_pkg;

    localparam int TIME_BITS = 16;
    localparam int ELAPSED_BITS = TIME_BITS + 1;

    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [ELAPSED_BITS-1:0] t_elapsed;

    localparam t_time RST_ON_TIME     = t_time'(200);
    localparam t_time RST_OFF_TIME    = t_time'(1000);
    localparam t_time RST_PULSE_TOTAL = t_time'(1);

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_ON    = 2'd2,
        REQ_OFF   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_ON        = 2'd1,
        MODE_PULSE_ON  = 2'd2,
        MODE_PULSE_OFF = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [15:0] pulse_count;
    } t_in_beat;

    typedef struct packed {
        logic       led_level;
        logic [1:0] led_mode;
    } t_out_beat;

endpackage

// ===== design/lptg_in_reg.sv =====
// Input register stage of the LED pulse train generator.
// Captures one request beat and holds it until the sequencer takes it; uses lptg_pkg.
module lptg_in_reg
    import lptg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_beat i_in_data,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_beat o_data
);

    logic     r_valid;
    t_in_beat r_data;
    logic     load;

    // stage frees up when empty or when the sequencer consumes it this cycle
    assign load       = !r_valid || i_take;
    assign o_in_stall = !load;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

endmodule

// ===== design/lptg_seq.sv =====
// LED sequencer: mode, stored pulse times, pulse and elapsed counters, invert
// register and the result register. Uses lptg_pkg.
module lptg_seq
    import lptg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic      r_invert;
    t_mode     r_mode,    n_mode;
    t_time     r_on,      n_on;
    t_time     r_off,     n_off;
    t_time     r_total,   n_total;
    t_time     r_done,    n_done;
    t_elapsed  r_elapsed, n_elapsed;
    logic      r_lit,     n_lit;
    logic      r_out_valid;
    t_out_beat r_out;

    t_req      req;
    t_elapsed  elapsed_inc;
    logic      adv;

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_take      = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign req         = t_req'(i_data.req_type);
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + t_elapsed'(1);

    always_comb begin
        n_mode    = r_mode;
        n_on      = r_on;
        n_off     = r_off;
        n_total   = r_total;
        n_done    = r_done;
        n_elapsed = r_elapsed;
        n_lit     = r_lit;
        case (req)
            REQ_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_mode == MODE_PULSE_ON) begin
                    if (elapsed_inc > {1'b0, r_on}) begin
                        n_lit     = 1'b0;
                        n_elapsed = '0;
                        n_mode    = MODE_PULSE_OFF;
                        if (r_total != '0 && r_done != '1) begin
                            n_done = r_done + t_time'(1);
                        end
                    end
                end else if (r_mode == MODE_PULSE_OFF) begin
                    if (elapsed_inc > {1'b0, r_off}) begin
                        n_elapsed = '0;
                        if (r_total == '0 || r_done < r_total) begin
                            n_lit  = 1'b1;
                            n_mode = MODE_PULSE_ON;
                        end else begin
                            n_mode = MODE_OFF;
                        end
                    end
                end
            end
            REQ_START: begin
                n_on    = t_time'(i_data.on_time);
                n_off   = t_time'(i_data.off_time);
                n_total = t_time'(i_data.pulse_count);
                n_done  = '0;
                n_mode  = MODE_PULSE_OFF;
            end
            REQ_ON: begin
                n_lit  = 1'b1;
                n_mode = MODE_ON;
            end
            REQ_OFF: begin
                n_lit  = 1'b0;
                n_mode = MODE_OFF;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            r_invert <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_on        <= RST_ON_TIME;
            r_off       <= RST_OFF_TIME;
            r_total     <= RST_PULSE_TOTAL;
            r_done      <= '0;
            r_elapsed   <= '0;
            r_lit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_mode    <= n_mode;
                r_on      <= n_on;
                r_off     <= n_off;
                r_total   <= n_total;
                r_done    <= n_done;
                r_elapsed <= n_elapsed;
                r_lit     <= n_lit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_out.led_level <= n_lit ^ r_invert;
            r_out.led_mode  <= n_mode;
        end
    end

    a_lit_in_on_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ON || r_mode == MODE_PULSE_ON) |-> r_lit)
        else $error("LED not lit in an on mode");

    a_dark_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OFF) |-> !r_lit)
        else $error("LED lit in off mode");

    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) |-> (r_done <= r_total))
        else $error("pulses done exceeds pulse total");

    a_phase_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && i_valid && req == REQ_TICK && r_mode == MODE_PULSE_ON
            && elapsed_inc > {1'b0, r_on}) |=> (r_elapsed == '0 && r_mode == MODE_PULSE_OFF))
        else $error("end of on phase did not clear elapsed time");

endmodule

// ===== design/led_pulse_train_generator_core.sv =====
// LED pulse train generator, top level.
// Path: a request beat is registered in the input register, then in the sequencer's result
// register; a stalled result holds both stages. Throughput: 1 beat per cycle unless
// the output stalls; input register feeds the sequencer, result register follows.
// Reset (synchronous, active low): mode off, on 200, off 1000, one pulse, counters zero,
// invert cleared, both stages empty. Built from lptg_in_reg and lptg_seq; uses lptg_pkg.
module led_pulse_train_generator_core
    import lptg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic     take;
    logic     stg_valid;
    t_in_beat stg_data;

    lptg_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_take     (take),
        .o_valid    (stg_valid),
        .o_data     (stg_data)
    );

    lptg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (stg_valid),
        .i_data      (stg_data),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
